// ===== rtl/sbs_pkg.sv =====
// shared constants and types for the selective background subtraction core
package sbs_pkg;
  localparam int unsigned FRAME_COLUMNS = 320;
  localparam int unsigned FRAME_ROWS    = 240;
  localparam int unsigned GREY_LEVELS   = 256;
  localparam int unsigned BIN_BITS      = 6;

  localparam int unsigned PIXELS   = FRAME_COLUMNS * FRAME_ROWS;
  localparam int unsigned POS_W    = $clog2(PIXELS);
  localparam int unsigned LVL_W    = (GREY_LEVELS > 2) ? $clog2(GREY_LEVELS) : 1;
  localparam int unsigned ROW_W    = GREY_LEVELS * BIN_BITS;
  localparam int unsigned SUM_W    = BIN_BITS + LVL_W;
  localparam logic [7:0]  GREY_MAX = 8'(GREY_LEVELS - 1);
  localparam logic [BIN_BITS-1:0] BIN_MAX = {BIN_BITS{1'b1}};
  localparam logic [6:0]  COUNT_MAX = 7'd127;

  // register indexes
  localparam logic [2:0] REG_TRAINING = 3'd0;
  localparam logic [2:0] REG_DIFF     = 3'd1;
  localparam logic [2:0] REG_CHANGE   = 3'd2;
  localparam logic [2:0] REG_WEIGHT   = 3'd3;
  localparam logic [2:0] REG_HOLD     = 3'd4;

  // change marks
  localparam logic [1:0] MARK_STABLE = 2'd0;
  localparam logic [1:0] MARK_UP     = 2'd1;
  localparam logic [1:0] MARK_DOWN   = 2'd2;
  localparam logic [1:0] MARK_NONE   = 2'd3;

  typedef struct packed {
    logic [7:0] bg;
    logic [7:0] prev;
    logic [1:0] mark;
    logic [7:0] hold;
  } pix_t;

  localparam int unsigned PIX_W = $bits(pix_t);
endpackage

// ===== rtl/sbs_ram.sv =====
// generic single-port synchronous ram with registered read
module sbs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== rtl/sbs_median.sv =====
// histogram median unit: one pass for the total, one pass for the running count
module sbs_median (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sbs_pkg::ROW_W-1:0]   row_i,
  output logic                        done_o,
  output logic [7:0]                  median_o
);
  import sbs_pkg::*;

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_SUM  = 2'd1;
  localparam logic [1:0] M_SCAN = 2'd2;

  logic [1:0]       st_q, st_d;
  logic [ROW_W-1:0] row_q;
  logic [LVL_W-1:0] k_q, k_d;
  logic [SUM_W-1:0] total_q, total_d, run_q, run_d;
  logic [BIN_BITS-1:0] bin;
  logic [SUM_W-1:0] run_n;
  logic             last, hit;

  assign bin   = row_q[k_q*BIN_BITS +: BIN_BITS];
  assign run_n = run_q + SUM_W'(bin);
  assign last  = (k_q == LVL_W'(GREY_LEVELS - 1));
  assign hit   = ({run_n, 1'b0} >= {1'b0, total_q});

  always_comb begin
    st_d     = st_q;
    k_d      = k_q;
    total_d  = total_q;
    run_d    = run_q;
    done_o   = 1'b0;
    median_o = GREY_MAX;
    unique case (st_q)
      M_IDLE: begin
        if (start_i) begin
          st_d    = M_SUM;
          k_d     = '0;
          total_d = '0;
          run_d   = '0;
        end
      end
      M_SUM: begin
        total_d = total_q + SUM_W'(bin);
        k_d     = k_q + 1'b1;
        if (last) begin
          st_d = M_SCAN;
          k_d  = '0;
        end
      end
      M_SCAN: begin
        run_d = run_n;
        k_d   = k_q + 1'b1;
        if (hit || last) begin
          done_o   = 1'b1;
          median_o = hit ? 8'(k_q) : GREY_MAX;
          st_d     = M_IDLE;
        end
      end
      default: st_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= M_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && st_q == M_IDLE) begin
      row_q <= row_i;
    end
    k_q     <= k_d;
    total_q <= total_d;
    run_q   <= run_d;
  end
endmodule

// ===== rtl/selective_background_subtraction_core.sv =====
// top level of the selective background subtraction core
//
// Pixels enter on the s_axis channel (tdata = pixel, tlast = end of frame) in
// raster order; results leave on m_axis (tdata = foreground, background level,
// change mark; tlast = frame done). Registers are written on the cfg channel,
// which is always ready. After reset the block runs a clearing pass over all
// FRAME_COLUMNS*FRAME_ROWS addresses of both memories, holding
// s_axis_tready low.
// One pixel is handled at a time: a training pixel is read, then its histogram
// row gets a read-modify-write, and it gives no result; a pixel after
// training goes through read, background update and result. On the
// median-forming frame the histogram row is walked bin by bin, once for the
// total and once more until the median is found.
// Results sit in an output register; when the receiver stalls, the next pixel
// is still taken and worked up to its result, then waits until the register
// frees.
module selective_background_subtraction_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] pixel
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [0] foreground, [8:1] background_level, [10:9] change_mark
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i
);
  import sbs_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_MEDIAN = 3'd3;
  localparam logic [2:0] ST_APPLY  = 3'd4;

  logic [2:0]       st_q, st_d;
  logic [POS_W-1:0] clr_q, pos_q, p_q;
  logic [6:0]       fc_q;
  logic [5:0]       train_q;
  logic [7:0]       diff_q, chg_q, hold_q;
  logic [8:0]       weight_q;
  logic [7:0]       px_q, bg_q;
  logic             eof_q, train_ph_q, median_ph_q;
  pix_t             pix_q;

  logic             accept;
  logic [7:0]       px_in;
  logic [POS_W-1:0] addr;
  logic             hist_we, pix_we;
  logic [ROW_W-1:0] hist_wdata, hist_rdata;
  pix_t             pix_wdata, pix_rdata, pix_new;
  logic             med_start, med_done;
  logic [7:0]       med_val;
  logic             out_free, leave_apply;

  // apply stage signals
  logic [8:0]  w;
  logic [16:0] blend;
  logic [7:0]  bg_new, hold_new, mag;
  logic        up;
  logic [1:0]  mark_new;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (st_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign px_in         = (s_axis_tdata > GREY_MAX) ? GREY_MAX : s_axis_tdata;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign leave_apply   = (st_q == ST_APPLY) && out_free;
  assign med_start     = (st_q == ST_READ) && median_ph_q;

  always_comb begin
    unique case (st_q)
      ST_CLEAR: addr = clr_q;
      ST_IDLE:  addr = pos_q;
      default:  addr = p_q;
    endcase
  end

  // histogram row update with saturation
  always_comb begin
    hist_wdata = hist_rdata;
    if (st_q == ST_CLEAR) begin
      hist_wdata = '0;
    end else if (hist_rdata[px_q[LVL_W-1:0]*BIN_BITS +: BIN_BITS] != BIN_MAX) begin
      hist_wdata[px_q[LVL_W-1:0]*BIN_BITS +: BIN_BITS] =
        hist_rdata[px_q[LVL_W-1:0]*BIN_BITS +: BIN_BITS] + 1'b1;
    end
  end
  assign hist_we = (st_q == ST_CLEAR) || ((st_q == ST_READ) && train_ph_q);

  // background update from the previous mark, then compare
  always_comb begin
    w        = (weight_q > 9'd256) ? 9'd256 : weight_q;
    blend    = 17'(w) * 17'(pix_q.prev) + 17'(9'd256 - w) * 17'(bg_q);
    bg_new   = bg_q;
    hold_new = pix_q.hold;
    case (pix_q.mark)
      MARK_STABLE: bg_new = blend[15:8];
      MARK_UP, MARK_DOWN: begin
        if (pix_q.hold < hold_q) begin
          hold_new = pix_q.hold + 1'b1;
        end else begin
          hold_new = '0;
          if (pix_q.mark == MARK_UP) begin
            if (bg_q < GREY_MAX) bg_new = bg_q + 1'b1;
          end else begin
            if (bg_q > 8'd0) bg_new = bg_q - 1'b1;
          end
        end
      end
      default: ;
    endcase
    up       = px_q > bg_new;
    mag      = up ? px_q - bg_new : bg_new - px_q;
    mark_new = (mag > chg_q) ? (up ? MARK_UP : MARK_DOWN) : MARK_STABLE;
    pix_new  = '{bg: bg_new, prev: px_q, mark: mark_new, hold: hold_new};
  end

  assign pix_wdata = (st_q == ST_CLEAR) ? '{bg: 8'd0, prev: 8'd0, mark: MARK_NONE, hold: 8'd0}
                                        : pix_new;
  assign pix_we    = (st_q == ST_CLEAR) || leave_apply;

  sbs_ram #(.Width(ROW_W), .Depth(PIXELS)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .addr_i  (addr),
    .wdata_i (hist_wdata),
    .rdata_o (hist_rdata)
  );

  sbs_ram #(.Width(PIX_W), .Depth(PIXELS)) u_pix_ram (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .addr_i  (addr),
    .wdata_i (pix_wdata),
    .rdata_o (pix_rdata)
  );

  sbs_median u_median (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (med_start),
    .row_i    (hist_rdata),
    .done_o   (med_done),
    .median_o (med_val)
  );

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_CLEAR:  if (clr_q == POS_W'(PIXELS - 1)) st_d = ST_IDLE;
      ST_IDLE:   if (accept) st_d = ST_READ;
      ST_READ: begin
        if (train_ph_q)       st_d = ST_IDLE;
        else if (median_ph_q) st_d = ST_MEDIAN;
        else                  st_d = ST_APPLY;
      end
      ST_MEDIAN: if (med_done) st_d = ST_APPLY;
      ST_APPLY:  if (out_free) st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= ST_CLEAR;
      clr_q         <= '0;
      pos_q         <= '0;
      fc_q          <= '0;
      train_q       <= 6'd55;
      diff_q        <= 8'd25;
      chg_q         <= 8'd15;
      weight_q      <= 9'd26;
      hold_q        <= 8'd220;
      m_axis_tvalid <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_TRAINING: train_q  <= cfg_data_i[5:0];
          REG_DIFF:     diff_q   <= cfg_data_i[7:0];
          REG_CHANGE:   chg_q    <= cfg_data_i[7:0];
          REG_WEIGHT:   weight_q <= cfg_data_i;
          REG_HOLD:     hold_q   <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (s_axis_tlast) begin
          pos_q <= '0;
          if (fc_q < COUNT_MAX) fc_q <= fc_q + 1'b1;
        end else begin
          pos_q <= (POS_W'(pos_q + 1'b1) == POS_W'(PIXELS)) ? '0 : POS_W'(pos_q + 1'b1);
        end
      end
      if (leave_apply) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q        <= px_in;
      eof_q       <= s_axis_tlast;
      p_q         <= pos_q;
      train_ph_q  <= fc_q < {1'b0, train_q};
      median_ph_q <= fc_q == {1'b0, train_q};
    end
    if (st_q == ST_READ) begin
      pix_q <= pix_rdata;
      bg_q  <= pix_rdata.bg;
    end
    if (st_q == ST_MEDIAN && med_done) begin
      bg_q <= med_val;
    end
    if (leave_apply) begin
      m_axis_tdata <= {5'd0, mark_new, bg_new, (mag > diff_q)};
      m_axis_tlast <= eof_q;
    end
  end
endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the selective background subtraction core
module tb_top;
  import sbs_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 300000;
  localparam int unsigned SETTLE_CYCLES  = 600;
  localparam int unsigned MAX_SHORT      = 16;

  typedef struct packed {
    logic       fg;
    logic [7:0] level;
    logic [1:0] mark;
    logic       done;
  } sbs_result_t;

  typedef struct {
    logic [7:0]  px;
    logic        eof;
    logic        typed;
    sbs_result_t want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [8:0]  cfg_data_i = '0;

  selective_background_subtraction_core dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [7:0]  bg_mem   [PIXELS];
  logic [7:0]  prev_mem [PIXELS];
  logic [1:0]  mark_mem [PIXELS];
  logic [7:0]  hold_mem [PIXELS];
  int unsigned hist_bins [int unsigned];
  int unsigned pos_q;
  logic [6:0]  frame_cnt;
  logic [5:0]  cfg_train;
  logic [7:0]  cfg_diff;
  logic [7:0]  cfg_change;
  logic [8:0]  cfg_weight;
  logic [7:0]  cfg_hold;

  sbs_result_t results_q[$];
  int unsigned errors;
  int unsigned pixels_sent;
  int unsigned results_seen;
  int unsigned median_frames;
  int unsigned burst_left;
  bit          no_gaps;
  logic [7:0]  scene[MAX_SHORT];

  // count a training pixel or work out the result of a live pixel
  function automatic void model_pixel(input logic [7:0] px, input logic eof);
    int unsigned p, total, run, k, w, key, mag;
    logic [7:0]  bg;
    logic [1:0]  mark;
    logic        up, found;
    sbs_result_t r;
    p = (pos_q >= PIXELS) ? 0 : pos_q;
    if (frame_cnt < 7'(cfg_train)) begin
      key = p * 256 + px;
      if (!hist_bins.exists(key)) hist_bins[key] = 0;
      if (hist_bins[key] < BIN_MAX) hist_bins[key]++;
    end else begin
      if (frame_cnt == 7'(cfg_train)) begin
        total = 0;
        run = 0;
        found = 1'b0;
        for (k = 0; k < GREY_LEVELS; k++)
          if (hist_bins.exists(p * 256 + k)) total += hist_bins[p * 256 + k];
        bg_mem[p] = GREY_MAX;
        for (k = 0; k < GREY_LEVELS; k++) begin
          if (hist_bins.exists(p * 256 + k)) run += hist_bins[p * 256 + k];
          if (!found && 2 * run >= total) begin
            bg_mem[p] = 8'(k);
            found = 1'b1;
          end
        end
      end
      bg = bg_mem[p];
      case (mark_mem[p])
        MARK_STABLE: begin
          w = (cfg_weight > 256) ? 256 : cfg_weight;
          bg = 8'((w * prev_mem[p] + (256 - w) * bg) >> 8);
        end
        MARK_UP, MARK_DOWN: begin
          if (hold_mem[p] < cfg_hold) begin
            hold_mem[p] = hold_mem[p] + 8'd1;
          end else begin
            if (mark_mem[p] == MARK_UP && bg < GREY_MAX) bg = bg + 8'd1;
            if (mark_mem[p] == MARK_DOWN && bg > 0) bg = bg - 8'd1;
            hold_mem[p] = '0;
          end
        end
        default: ;
      endcase
      bg_mem[p] = bg;
      up = px > bg;
      mag = up ? px - bg : bg - px;
      mark = (mag > cfg_change) ? (up ? MARK_UP : MARK_DOWN) : MARK_STABLE;
      mark_mem[p] = mark;
      prev_mem[p] = px;
      r.fg = mag > cfg_diff;
      r.level = bg;
      r.mark = mark;
      r.done = eof;
      results_q.push_back(r);
      if (frame_cnt == 7'(cfg_train) && eof) median_frames++;
    end
    if (eof) begin
      pos_q = 0;
      if (frame_cnt < COUNT_MAX) frame_cnt++;
    end else begin
      pos_q = (p + 1 >= PIXELS) ? 0 : p + 1;
    end
  endfunction

  task automatic send_pixel(input logic [7:0] px, input logic eof);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tlast  <= eof;
    do @(posedge clk_i); while (!s_axis_tready);
    model_pixel(px, eof);
    pixels_sent++;
    burst_left--;
  endtask

  // stop sending and let every outstanding pixel finish
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [8:0] train, input logic [8:0] diff,
                              input logic [8:0] change, input logic [8:0] weight,
                              input logic [8:0] hold);
    logic [8:0] vals[5];
    logic [2:0] idx[5];
    vals = '{train, diff, change, weight, hold};
    idx  = '{REG_TRAINING, REG_DIFF, REG_CHANGE, REG_WEIGHT, REG_HOLD};
    for (int i = 0; i < 5; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx[i])
        REG_TRAINING: cfg_train  = vals[i][5:0];
        REG_DIFF:     cfg_diff   = vals[i][7:0];
        REG_CHANGE:   cfg_change = vals[i][7:0];
        REG_WEIGHT:   cfg_weight = vals[i];
        REG_HOLD:     cfg_hold   = vals[i][7:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // mostly a steady scene with noise, sometimes a step, a random pixel or a 0/255 extreme
  function automatic logic [7:0] scene_pixel(input int unsigned p);
    int unsigned roll;
    int          v;
    roll = $urandom_range(0, 99);
    if (roll < 8) scene[p] = 8'($urandom);
    if (roll >= 8 && roll < 20) return 8'($urandom);
    if (roll >= 20 && roll < 24) return (roll[0]) ? 8'd255 : 8'd0;
    v = int'(scene[p]) + $urandom_range(0, 8) - 4;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  task automatic run_frames(input int unsigned n_frames, input int unsigned max_len);
    int unsigned len;
    for (int f = 0; f < n_frames; f++) begin
      len = $urandom_range(1, max_len);
      for (int i = 0; i < len; i++) send_pixel(scene_pixel(i), i == len - 1);
    end
  endtask

  // receiver runs in repeating stretches: free-running, heavily stalled, then lightly stalled
  int unsigned rx_cycle = 0;
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle[10:9] == 2'd0) m_axis_tready <= 1'b1;
    else if (rx_cycle[10:9] == 2'd1) m_axis_tready <= ($urandom_range(0, 7) == 0);
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk_i) begin : result_check
    sbs_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (results_q.size() == 0) begin
        $display("%0t: unexpected result tdata=%h tlast=%b", $time, m_axis_tdata,
                 m_axis_tlast);
        errors++;
      end else begin
        want = results_q.pop_front();
        if (m_axis_tdata[0] !== want.fg) begin
          $display("%0t: foreground expected %b actual %b", $time, want.fg,
                   m_axis_tdata[0]);
          errors++;
        end
        if (m_axis_tdata[8:1] !== want.level) begin
          $display("%0t: background_level expected %0d actual %0d", $time, want.level,
                   m_axis_tdata[8:1]);
          errors++;
        end
        if (m_axis_tdata[10:9] !== want.mark) begin
          $display("%0t: change_mark expected %0d actual %0d", $time, want.mark,
                   m_axis_tdata[10:9]);
          errors++;
        end
        if (m_axis_tlast !== want.done) begin
          $display("%0t: frame_done expected %b actual %b", $time, want.done,
                   m_axis_tlast);
          errors++;
        end
      end
    end
  end

  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time,
               results_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  stim_row_t directed[13] = '{
    // median frame right after reset with no training: background starts at 0
    '{8'd0,   1'b0, 1'b1, '{1'b0, 8'd0, MARK_STABLE, 1'b0}},
    '{8'd255, 1'b0, 1'b1, '{1'b1, 8'd0, MARK_UP, 1'b0}},
    '{8'd1,   1'b0, 1'b1, '{1'b1, 8'd0, MARK_UP, 1'b0}},
    '{8'd128, 1'b1, 1'b1, '{1'b1, 8'd0, MARK_UP, 1'b1}},
    // hold count 0 steps at once, full blend weight copies previous pixel
    '{8'd0,   1'b0, 1'b0, '{1'b0, 8'd0, MARK_STABLE, 1'b0}},
    '{8'd255, 1'b0, 1'b0, '{1'b0, 8'd0, MARK_STABLE, 1'b0}},
    '{8'd0,   1'b0, 1'b0, '{1'b0, 8'd0, MARK_STABLE, 1'b0}},
    '{8'd170, 1'b0, 1'b0, '{1'b0, 8'd0, MARK_STABLE, 1'b0}},
    '{8'd85,  1'b1, 1'b0, '{1'b0, 8'd0, MARK_STABLE, 1'b0}},
    '{8'd255, 1'b0, 1'b0, '{1'b0, 8'd0, MARK_STABLE, 1'b0}},
    '{8'd255, 1'b0, 1'b0, '{1'b0, 8'd0, MARK_STABLE, 1'b0}},
    '{8'd1,   1'b1, 1'b0, '{1'b0, 8'd0, MARK_STABLE, 1'b0}},
    '{8'd254, 1'b1, 1'b0, '{1'b0, 8'd0, MARK_STABLE, 1'b0}}
  };

  initial begin
    for (int i = 0; i < PIXELS; i++) begin
      bg_mem[i] = '0;
      prev_mem[i] = '0;
      mark_mem[i] = MARK_NONE;
      hold_mem[i] = '0;
    end
    for (int i = 0; i < MAX_SHORT; i++) scene[i] = 8'($urandom);
    pos_q = 0;
    frame_cnt = '0;
    cfg_train = 6'd55;
    cfg_diff = 8'd25;
    cfg_change = 8'd15;
    cfg_weight = 9'd26;
    cfg_hold = 8'd220;
    errors = 0;
    pixels_sent = 0;
    results_seen = 0;
    median_frames = 0;
    burst_left = 0;
    no_gaps = 1'b0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_config(9'd0, 9'd0, 9'd0, 9'd256, 9'd0);
    foreach (directed[i]) begin
      send_pixel(directed[i].px, directed[i].eof);
      if (directed[i].typed && results_q[$] !== directed[i].want) begin
        $display("%0t: row %0d expected %p actual %p", $time, i, directed[i].want,
                 results_q[$]);
        errors++;
      end
    end
    drain();

    // back into training, then a median frame and an update frame
    write_config(9'd5, 9'd255, 9'd255, 9'd511, 9'd255);
    run_frames(3, 8);
    drain();

    write_config(9'd5, 9'd10, 9'd5, 9'd0, 9'd2);
    run_frames(20, 8);
    drain();

    // retrain with long runs of the same level
    write_config(9'd63, 9'd25, 9'd15, 9'd26, 9'd220);
    for (int f = 0; f < 60; f++) send_pixel((f % 5 == 4) ? 8'd17 : 8'd200, 1'b1);
    run_frames(12, 6);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_config(9'($urandom_range(0, 63)), 9'($urandom_range(0, 255)),
                   9'($urandom_range(0, 40)), 9'($urandom_range(0, 511)),
                   9'($urandom_range(0, 6)));
      no_gaps = (ph == 2);
      run_frames(18, 12);
      drain();
    end

    write_config(9'd1, 9'd255, 9'd255, 9'd300, 9'd255);
    run_frames(10, 10);
    drain();

    $display("%0d pixels sent, %0d results checked, %0d median frames, %0d mismatches",
             pixels_sent, results_seen, median_frames, errors);
    $display("covered training, median forming, blend, hold and step, config extremes");
    if (errors == 0 && results_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0t: %0d results never arrived", $time, results_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
